// ===== rtl/srw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srw_pkg
// types, codes and helpers for the sample reorder window
// ----------------------------------------------------------------------------
package srw_pkg;

    localparam int unsigned WINDOW  = 1024;
    localparam int unsigned SLOT_W  = $clog2(WINDOW);
    localparam int unsigned HELD_W  = SLOT_W + 1;
    localparam int unsigned MAX_RUN = 25;
    localparam int unsigned RUN_W   = 5;
    localparam int unsigned MISS_W  = 17;

    localparam logic [7:0]  STATUS_SIZE   = 8'd20;
    localparam logic [7:0]  GAP_SIZE      = 8'd8;
    localparam logic [2:0]  SAMPLE_BYTES  = 3'd6;
    localparam logic [15:0] RATE_WORD     = 16'd250;
    localparam logic [15:0] CHAN_WORD     = 16'd3;
    localparam logic [15:0] HOLDOFF_RESET = 16'd100;

    // command codes
    localparam logic [2:0] CMD_STATUS = 3'd0;
    localparam logic [2:0] CMD_DATA   = 3'd1;
    localparam logic [2:0] CMD_GAP    = 3'd2;
    localparam logic [2:0] CMD_TICK   = 3'd3;
    localparam logic [2:0] CMD_LOOKUP = 3'd4;

    // result codes
    localparam logic [2:0] K_ACCEPT  = 3'd0;
    localparam logic [2:0] K_DELIVER = 3'd1;
    localparam logic [2:0] K_DROP    = 3'd2;
    localparam logic [2:0] K_IGNORE  = 3'd3;
    localparam logic [2:0] K_HIT     = 3'd4;
    localparam logic [2:0] K_MISS    = 3'd5;
    localparam logic [2:0] K_REQ     = 3'd6;
    localparam logic [2:0] K_NOREQ   = 3'd7;

    // register indexes
    localparam logic CFG_SESSION = 1'b0;
    localparam logic CFG_HOLDOFF = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RAISE,
        ST_SAMPLE_CHK,
        ST_SAMPLE_EV,
        ST_READ_EV,
        ST_SCAN_P,
        ST_SCAN_M,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] packet_session;
        logic [7:0]  payload_size;
        logic [31:0] seq_start;
        logic [7:0]  sample_count;
        logic [4:0]  sample_index;
        logic [15:0] chan_a;
        logic [15:0] chan_b;
        logic [15:0] chan_c;
        logic [31:0] word_a;
        logic [31:0] word_b;
    } in_t;

    typedef struct packed {
        logic [2:0]        result_kind;
        logic [31:0]       out_sequence;
        logic [15:0]       out_chan_a;
        logic [15:0]       out_chan_b;
        logic [15:0]       out_chan_c;
        logic [RUN_W-1:0]  request_run;
        logic [MISS_W-1:0] missing_count;
        logic [31:0]       expired_total;
        logic [31:0]       duplicate_total;
        logic [31:0]       received_total;
    } out_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] seq;
        logic [15:0] chan_a;
        logic [15:0] chan_b;
        logic [15:0] chan_c;
    } slot_t;

    function automatic logic [31:0] max32(input logic [31:0] a, input logic [31:0] b);
        return (a > b) ? a : b;
    endfunction

    // lowest floor allowed for a given next sequence
    function automatic logic [31:0] bound_floor(input logic [31:0] n);
        return (n > 32'(WINDOW)) ? (n - 32'(WINDOW)) : 32'd0;
    endfunction

    function automatic out_t make_res(input logic [2:0] kind, input logic [31:0] seq,
                                      input logic [15:0] a, input logic [15:0] b,
                                      input logic [15:0] c, input logic [RUN_W-1:0] run);
        out_t r;
        r = '0;
        r.result_kind  = kind;
        r.out_sequence = seq;
        r.out_chan_a   = a;
        r.out_chan_b   = b;
        r.out_chan_c   = c;
        r.request_run  = run;
        return r;
    endfunction

endpackage

// ===== rtl/sample_reorder_window_with_nack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_reorder_window_with_nack
// selective repeat receive window for sequence-numbered 3-channel samples
// ----------------------------------------------------------------------------
// usage
//   in_valid/in_ready carry one command per transaction: status, data sample,
//   gap, request tick or read query. out_valid/out_ready return exactly one
//   result per command, with the missing count and the three totals attached.
//   cfg_we/cfg_index/cfg_data write session_id (0) and request_holdoff (1);
//   write only while the block is idle.
// timing, one command at a time
//   any floor move adds a sweep over the whole slot memory; a request tick
//   walks the window one slot per cycle. the single read port of the slot
//   memory sets the pace.
// reset
//   after reset the slot memory is swept clear with in_ready low;
//   configuration writes are taken during that time.
// stall
//   the result sits in an output register; a new command is accepted while
//   it waits, and the block holds its next result until out_ready frees it.
// ----------------------------------------------------------------------------
module sample_reorder_window_with_nack (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [31:0]   cfg_data,
    input  logic          in_valid,
    output logic          in_ready,
    input  srw_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output srw_pkg::out_t out_data
);
    import srw_pkg::*;

    // slot memory, one read and one write port, registered read
    slot_t mem [WINDOW];
    slot_t rd_data;
    logic [SLOT_W-1:0] rd_addr;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_wa;
    slot_t             mem_wd;

    state_t state_reg, state_next;
    logic [SLOT_W-1:0] clr_reg, clr_next;
    in_t   item_reg, item_next;
    logic [31:0] session_reg;
    logic [15:0] holdoff_reg;
    logic [31:0] floor_reg, floor_next;
    logic [31:0] next_reg, next_next;
    logic        started_reg, started_next;
    logic [HELD_W-1:0] held_reg, held_next;
    logic        rej_reg, rej_next;
    logic [31:0] exp_reg, exp_next;
    logic [31:0] dup_reg, dup_next;
    logic [31:0] rcv_reg, rcv_next;
    logic [31:0] pstart_reg, pstart_next;
    logic [RUN_W-1:0] prun_reg, prun_next;
    logic [31:0] lastreq_reg, lastreq_next;
    logic [31:0] target_reg, target_next;
    logic [HELD_W-1:0] saved_reg, saved_next;
    logic [31:0] iss_reg, iss_next;
    logic        ev_vld_reg, ev_vld_next;
    logic [31:0] ev_seq_reg, ev_seq_next;
    logic [31:0] rstart_reg, rstart_next;
    logic [RUN_W-1:0] run_reg, run_next;
    out_t  res_reg, res_next;
    out_t  out_reg, out_next;
    logic  out_vld_reg, out_vld_next;

    // decode of a new command
    logic        in_match, st_ok, dt_rej, gp_ok;
    logic [31:0] st_floor, st_nxt, st_target;
    logic [32:0] dt_sum;
    logic [31:0] dt_nxt, dt_target, gp_target;
    logic [10:0] dt_bytes;

    assign in_match  = (in_data.packet_session == session_reg);
    assign st_ok     = in_match && (in_data.payload_size == STATUS_SIZE)
                       && (in_data.chan_a == RATE_WORD) && (in_data.chan_b == CHAN_WORD)
                       && (in_data.word_a <= in_data.word_b);
    assign st_floor  = started_reg ? floor_reg : in_data.word_b;
    assign st_nxt    = started_reg ? max32(next_reg, in_data.word_b) : in_data.word_b;
    assign st_target = max32(max32(st_floor, in_data.word_a), bound_floor(st_nxt));

    assign dt_bytes  = 11'(in_data.sample_count) * 11'(SAMPLE_BYTES);
    assign dt_sum    = {1'b0, in_data.seq_start} + 33'(in_data.sample_count);
    assign dt_rej    = !(in_match && started_reg && (in_data.sample_count != 8'd0)
                         && (in_data.sample_count <= 8'(MAX_RUN))
                         && (11'(in_data.payload_size) == dt_bytes) && !dt_sum[32]);
    assign dt_nxt    = max32(next_reg, dt_sum[31:0]);
    assign dt_target = max32(floor_reg, bound_floor(dt_nxt));

    assign gp_ok     = in_match && (in_data.payload_size == GAP_SIZE)
                       && (in_data.word_a <= next_reg);
    assign gp_target = max32(max32(floor_reg, in_data.word_a), bound_floor(next_reg));

    // checks on the slot returned for ev_seq_reg
    logic        hold_e, raise_hit, sm_ok;
    logic [32:0] sm_sum;
    logic [HELD_W-1:0] saved_tot;
    logic [31:0] pend_end, now_w;

    assign hold_e    = (ev_seq_reg >= floor_reg) && (ev_seq_reg < next_reg)
                       && rd_data.valid && (rd_data.seq == ev_seq_reg);
    assign raise_hit = ev_vld_reg && rd_data.valid && (rd_data.seq < target_reg);
    assign saved_tot = saved_reg + HELD_W'(raise_hit);
    assign sm_sum    = {1'b0, item_reg.seq_start} + 33'(item_reg.sample_index);
    assign sm_ok     = (item_reg.packet_session == session_reg) && started_reg && !rej_reg
                       && (8'(item_reg.sample_index) < item_reg.sample_count) && !sm_sum[32];
    assign pend_end  = pstart_reg + 32'(prun_reg);
    assign now_w     = item_reg.word_a;

    // next state and datapath
    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        item_next    = item_reg;
        floor_next   = floor_reg;
        next_next    = next_reg;
        started_next = started_reg;
        held_next    = held_reg;
        rej_next     = rej_reg;
        exp_next     = exp_reg;
        dup_next     = dup_reg;
        rcv_next     = rcv_reg;
        pstart_next  = pstart_reg;
        prun_next    = prun_reg;
        lastreq_next = lastreq_reg;
        target_next  = target_reg;
        saved_next   = saved_reg;
        iss_next     = iss_reg;
        ev_vld_next  = 1'b0;
        ev_seq_next  = ev_seq_reg;
        rstart_next  = rstart_reg;
        run_next     = run_reg;
        res_next     = res_reg;
        out_next     = out_reg;
        out_vld_next = out_vld_reg && !out_ready;

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                    state_next = ST_IDLE;
            end

            ST_IDLE:
            begin
                if (in_valid)
                begin
                    item_next   = in_data;
                    saved_next  = '0;
                    iss_next    = '0;
                    state_next  = ST_DONE;
                    res_next    = make_res(K_IGNORE, '0, '0, '0, '0, '0);
                    case (in_data.cmd)
                        CMD_STATUS:
                        begin
                            if (st_ok)
                            begin
                                started_next = 1'b1;
                                floor_next   = st_floor;
                                next_next    = st_nxt;
                                res_next     = make_res(K_ACCEPT, '0, '0, '0, '0, '0);
                                if (st_target > st_floor)
                                begin
                                    target_next = st_target;
                                    state_next  = ST_RAISE;
                                end
                            end
                        end
                        CMD_DATA:
                        begin
                            state_next = ST_SAMPLE_CHK;
                            if (in_data.sample_index == '0)
                            begin
                                rej_next = dt_rej;
                                if (!dt_rej)
                                begin
                                    next_next = dt_nxt;
                                    if (dt_target > floor_reg)
                                    begin
                                        target_next = dt_target;
                                        state_next  = ST_RAISE;
                                    end
                                end
                            end
                        end
                        CMD_GAP:
                        begin
                            if (gp_ok)
                            begin
                                res_next = make_res(K_ACCEPT, '0, '0, '0, '0, '0);
                                if (gp_target > floor_reg)
                                begin
                                    target_next = gp_target;
                                    state_next  = ST_RAISE;
                                end
                            end
                        end
                        CMD_TICK:
                        begin
                            if (!started_reg)
                                res_next = make_res(K_NOREQ, '0, '0, '0, '0, '0);
                            else if (prun_reg != '0)
                            begin
                                iss_next   = pstart_reg;
                                state_next = ST_SCAN_P;
                            end
                            else
                            begin
                                iss_next   = floor_reg;
                                state_next = ST_SCAN_M;
                            end
                        end
                        CMD_LOOKUP:
                        begin
                            ev_seq_next = in_data.seq_start;
                            state_next  = ST_READ_EV;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_RAISE:
            begin
                iss_next    = iss_reg + 32'd1;
                ev_vld_next = 1'b1;
                ev_seq_next = iss_reg;
                if (raise_hit)
                    saved_next = saved_tot;
                if (ev_vld_reg && (ev_seq_reg == 32'(WINDOW - 1)))
                begin
                    floor_next  = target_reg;
                    exp_next    = exp_reg + (target_reg - floor_reg) - 32'(saved_tot);
                    held_next   = held_reg - saved_tot;
                    ev_vld_next = 1'b0;
                    state_next  = (item_reg.cmd == CMD_DATA) ? ST_SAMPLE_CHK : ST_DONE;
                end
            end

            ST_SAMPLE_CHK:
            begin
                state_next = ST_DONE;
                if (!sm_ok)
                    res_next = make_res(K_IGNORE, '0, '0, '0, '0, '0);
                else if (sm_sum[31:0] < floor_reg)
                    res_next = make_res(K_DROP, '0, '0, '0, '0, '0);
                else
                begin
                    ev_seq_next = sm_sum[31:0];
                    state_next  = ST_SAMPLE_EV;
                end
            end

            ST_SAMPLE_EV:
            begin
                state_next = ST_DONE;
                if (hold_e)
                begin
                    dup_next = dup_reg + 32'd1;
                    res_next = make_res(K_DROP, '0, '0, '0, '0, '0);
                end
                else if (ev_seq_reg < next_reg)
                begin
                    held_next = held_reg + HELD_W'(!rd_data.valid);
                    rcv_next  = rcv_reg + 32'd1;
                    res_next  = make_res(K_DELIVER, ev_seq_reg, item_reg.chan_a,
                                         item_reg.chan_b, item_reg.chan_c, '0);
                end
                else
                    res_next = make_res(K_IGNORE, '0, '0, '0, '0, '0);
            end

            ST_READ_EV:
            begin
                state_next = ST_DONE;
                if (hold_e)
                    res_next = make_res(K_HIT, ev_seq_reg, rd_data.chan_a,
                                        rd_data.chan_b, rd_data.chan_c, '0);
                else
                    res_next = make_res(K_MISS, ev_seq_reg, '0, '0, '0, '0);
            end

            ST_SCAN_P:
            begin
                iss_next    = iss_reg + 32'd1;
                ev_vld_next = 1'b1;
                ev_seq_next = iss_reg;
                if (ev_vld_reg)
                begin
                    if (ev_seq_reg >= pend_end)
                    begin
                        prun_next   = '0;
                        iss_next    = floor_reg;
                        ev_vld_next = 1'b0;
                        state_next  = ST_SCAN_M;
                    end
                    else if ((ev_seq_reg >= floor_reg) && !hold_e)
                    begin
                        state_next = ST_DONE;
                        if ((now_w - lastreq_reg) < 32'(holdoff_reg))
                            res_next = make_res(K_NOREQ, '0, '0, '0, '0, '0);
                        else
                        begin
                            lastreq_next = now_w;
                            res_next = make_res(K_REQ, pstart_reg, '0, '0, '0, prun_reg);
                        end
                    end
                end
            end

            ST_SCAN_M:
            begin
                iss_next    = iss_reg + 32'd1;
                ev_vld_next = 1'b1;
                ev_seq_next = iss_reg;
                if (ev_vld_reg)
                begin
                    if (ev_seq_reg >= next_reg)
                    begin
                        state_next = ST_DONE;
                        res_next   = make_res(K_NOREQ, '0, '0, '0, '0, '0);
                    end
                    else if (!hold_e)
                    begin
                        rstart_next = ev_seq_reg;
                        run_next    = RUN_W'(1);
                        state_next  = ST_RUN;
                    end
                end
            end

            ST_RUN:
            begin
                iss_next    = iss_reg + 32'd1;
                ev_vld_next = 1'b1;
                ev_seq_next = iss_reg;
                if ((run_reg == RUN_W'(MAX_RUN)) || (ev_seq_reg >= next_reg) || hold_e)
                begin
                    pstart_next  = rstart_reg;
                    prun_next    = run_reg;
                    lastreq_next = now_w;
                    state_next   = ST_DONE;
                    res_next     = make_res(K_REQ, rstart_reg, '0, '0, '0, run_reg);
                end
                else
                    run_next = run_reg + 1'b1;
            end

            ST_DONE:
            begin
                if (!out_vld_reg || out_ready)
                begin
                    out_next                 = res_reg;
                    out_next.missing_count   = MISS_W'(next_reg - floor_reg) - MISS_W'(held_reg);
                    out_next.expired_total   = exp_reg;
                    out_next.duplicate_total = dup_reg;
                    out_next.received_total  = rcv_reg;
                    out_vld_next             = 1'b1;
                    state_next               = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // handshake and memory controls
    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
        mem_we   = 1'b0;
        mem_wa   = ev_seq_reg[SLOT_W-1:0];
        mem_wd   = rd_data;
        rd_addr  = iss_reg[SLOT_W-1:0];
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = clr_reg;
                mem_wd = '0;
            end
            ST_IDLE:
            begin
                rd_addr = in_data.seq_start[SLOT_W-1:0];
            end
            ST_RAISE:
            begin
                // drop slots that the new floor passes
                mem_we       = raise_hit;
                mem_wd.valid = 1'b0;
            end
            ST_SAMPLE_CHK:
            begin
                rd_addr = sm_sum[SLOT_W-1:0];
            end
            ST_SAMPLE_EV:
            begin
                mem_we = !hold_e && (ev_seq_reg < next_reg);
                mem_wd = '{valid: 1'b1, seq: ev_seq_reg, chan_a: item_reg.chan_a,
                           chan_b: item_reg.chan_b, chan_c: item_reg.chan_c};
            end
            default:
            begin
                rd_addr = iss_reg[SLOT_W-1:0];
            end
        endcase
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_data <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            session_reg <= '0;
            holdoff_reg <= HOLDOFF_RESET;
            floor_reg   <= '0;
            next_reg    <= '0;
            started_reg <= 1'b0;
            held_reg    <= '0;
            rej_reg     <= 1'b0;
            exp_reg     <= '0;
            dup_reg     <= '0;
            rcv_reg     <= '0;
            pstart_reg  <= '0;
            prun_reg    <= '0;
            lastreq_reg <= '0;
            saved_reg   <= '0;
            ev_vld_reg  <= 1'b0;
            run_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            floor_reg   <= floor_next;
            next_reg    <= next_next;
            started_reg <= started_next;
            held_reg    <= held_next;
            rej_reg     <= rej_next;
            exp_reg     <= exp_next;
            dup_reg     <= dup_next;
            rcv_reg     <= rcv_next;
            pstart_reg  <= pstart_next;
            prun_reg    <= prun_next;
            lastreq_reg <= lastreq_next;
            saved_reg   <= saved_next;
            ev_vld_reg  <= ev_vld_next;
            run_reg     <= run_next;
            out_vld_reg <= out_vld_next;
            if (cfg_we)
            begin
                if (cfg_index == CFG_SESSION)
                    session_reg <= cfg_data;
                else
                    holdoff_reg <= cfg_data[15:0];
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        target_reg <= target_next;
        iss_reg    <= iss_next;
        ev_seq_reg <= ev_seq_next;
        rstart_reg <= rstart_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
    end

    // the count of held slots can never exceed the ring
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= HELD_W'(WINDOW))
        else $error("held count above window size");

    // floor never passes next and the span fits the ring between commands
    a_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> ((floor_reg <= next_reg)
                                    && ((next_reg - floor_reg) <= 32'(WINDOW))))
        else $error("window span out of range");

    // slot memory is never written while waiting for a command
    a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mem_we)
        else $error("slot write while idle");

    // a new result only comes from the result stage
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_vld_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside result stage");

    // a pending run stays within the request limit
    a_run_bound: assert property (@(posedge clk) disable iff (!rst_n)
        prun_reg <= RUN_W'(MAX_RUN))
        else $error("pending run too long");

endmodule

// ===== tb/srw_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srw_checker
// watches the command and result channels of the sample reorder window,
// keeps its own copy of the window state, predicts one result per command
// transaction and compares each result transaction field by field
// ----------------------------------------------------------------------------
module srw_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_index,
    input  logic [31:0]   cfg_data,
    input  logic          in_valid,
    input  logic          in_ready,
    input  srw_pkg::in_t  in_data,
    input  logic          out_valid,
    input  logic          out_ready,
    input  srw_pkg::out_t out_data,
    output int            fail_count,
    output int            outstanding
);
    import srw_pkg::*;

    logic [31:0] session_reg;
    logic [15:0] holdoff_reg;

    bit          slot_held [WINDOW];
    logic [31:0] slot_seq  [WINDOW];
    logic [47:0] slot_val  [WINDOW];
    logic [31:0] floor_seq, next_seq;
    bit          started, rejected;
    int unsigned held;
    logic [31:0] expired_cnt, dup_cnt, recv_cnt;
    logic [31:0] pend_start, last_req;
    int unsigned pend_run;

    out_t expected_results[$];
    int   errs;
    int   printed;

    assign fail_count = errs;

    task automatic report(input string what, input longint got, input longint want);
        errs++;
        if (printed < 40)
        begin
            printed++;
            $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        end
    endtask

    function automatic bit holds(input logic [31:0] s);
        int unsigned i;
        i = s % WINDOW;
        return s >= floor_seq && s < next_seq && slot_held[i] && slot_seq[i] == s;
    endfunction

    function automatic void raise_floor(input logic [31:0] f);
        logic [31:0] saved;
        saved = 0;
        if (f <= floor_seq)
            return;
        for (int i = 0; i < WINDOW; i++)
        begin
            if (slot_held[i] && slot_seq[i] >= floor_seq && slot_seq[i] < f)
            begin
                slot_held[i] = 0;
                saved++;
            end
        end
        expired_cnt += f - floor_seq - saved;
        held -= saved;
        floor_seq = f;
    endfunction

    function automatic void bound_window();
        if (next_seq > WINDOW)
            raise_floor(next_seq - WINDOW);
    endfunction

    // re-request scan: pending run first, then the first missing run
    function automatic logic [2:0] tick_scan(input logic [31:0] now);
        longint s, stop;
        int unsigned run;
        if (!started)
            return K_NOREQ;
        if (pend_run != 0)
        begin
            stop = longint'(pend_start) + pend_run;
            for (s = pend_start; s < stop; s++)
            begin
                if (s >= floor_seq && !holds(s[31:0]))
                begin
                    if (32'(now - last_req) < {16'd0, holdoff_reg})
                        return K_NOREQ;
                    last_req = now;
                    return K_REQ;
                end
            end
            pend_run = 0;
        end
        for (s = floor_seq; s < next_seq; s++)
        begin
            if (!holds(s[31:0]))
            begin
                run = 1;
                while (run < MAX_RUN && s + run < next_seq && !holds(32'(s + run)))
                    run++;
                pend_start = s[31:0];
                pend_run = run;
                last_req = now;
                return K_REQ;
            end
        end
        return K_NOREQ;
    endfunction

    function automatic out_t window_result(input in_t it);
        out_t r;
        bit m;
        logic [31:0] e, sq;
        int unsigned si;
        r = '0;
        r.result_kind = K_IGNORE;
        m = (it.packet_session == session_reg);
        case (it.cmd)
            CMD_STATUS:
                if (m && it.payload_size == STATUS_SIZE && it.chan_a == RATE_WORD &&
                    it.chan_b == CHAN_WORD && it.word_a <= it.word_b)
                begin
                    if (!started)
                    begin
                        floor_seq = it.word_b;
                        next_seq = it.word_b;
                        started = 1;
                    end
                    if (it.word_b > next_seq)
                        next_seq = it.word_b;
                    raise_floor(it.word_a);
                    bound_window();
                    r.result_kind = K_ACCEPT;
                end
            CMD_DATA:
            begin
                if (it.sample_index == 0)
                begin
                    rejected = !(m && started && it.sample_count >= 1 &&
                                 it.sample_count <= MAX_RUN &&
                                 int'(it.payload_size) == int'(it.sample_count) * 6 &&
                                 it.seq_start <= 32'hFFFF_FFFF - it.sample_count);
                    if (!rejected)
                    begin
                        e = it.seq_start + it.sample_count;
                        if (e > next_seq)
                            next_seq = e;
                        bound_window();
                    end
                end
                if (m && started && !rejected && it.sample_index < it.sample_count &&
                    {1'b0, it.seq_start} + it.sample_index <= 33'h0_FFFF_FFFF)
                begin
                    sq = it.seq_start + it.sample_index;
                    si = sq % WINDOW;
                    if (sq < floor_seq)
                        r.result_kind = K_DROP;
                    else if (holds(sq))
                    begin
                        dup_cnt++;
                        r.result_kind = K_DROP;
                    end
                    else if (sq < next_seq)
                    begin
                        if (!slot_held[si])
                            held++;
                        slot_held[si] = 1;
                        slot_seq[si] = sq;
                        slot_val[si] = {it.chan_a, it.chan_b, it.chan_c};
                        recv_cnt++;
                        r.result_kind = K_DELIVER;
                        r.out_sequence = sq;
                        r.out_chan_a = it.chan_a;
                        r.out_chan_b = it.chan_b;
                        r.out_chan_c = it.chan_c;
                    end
                end
            end
            CMD_GAP:
                if (m && it.payload_size == GAP_SIZE && it.word_a <= next_seq)
                begin
                    raise_floor(it.word_a);
                    bound_window();
                    r.result_kind = K_ACCEPT;
                end
            CMD_TICK:
            begin
                r.result_kind = tick_scan(it.word_a);
                if (r.result_kind == K_REQ)
                begin
                    r.out_sequence = pend_start;
                    r.request_run = RUN_W'(pend_run);
                end
            end
            CMD_LOOKUP:
            begin
                r.out_sequence = it.seq_start;
                if (holds(it.seq_start))
                begin
                    si = it.seq_start % WINDOW;
                    r.result_kind = K_HIT;
                    {r.out_chan_a, r.out_chan_b, r.out_chan_c} = slot_val[si];
                end
                else
                    r.result_kind = K_MISS;
            end
            default: ;
        endcase
        r.missing_count = MISS_W'(next_seq - floor_seq - held);
        r.expired_total = expired_cnt;
        r.duplicate_total = dup_cnt;
        r.received_total = recv_cnt;
        return r;
    endfunction

    task automatic compare_result(input out_t got, input out_t want);
        if (got.result_kind != want.result_kind)
            report("result_kind", got.result_kind, want.result_kind);
        if (got.out_sequence != want.out_sequence)
            report("out_sequence", got.out_sequence, want.out_sequence);
        if (got.out_chan_a != want.out_chan_a)
            report("out_chan_a", got.out_chan_a, want.out_chan_a);
        if (got.out_chan_b != want.out_chan_b)
            report("out_chan_b", got.out_chan_b, want.out_chan_b);
        if (got.out_chan_c != want.out_chan_c)
            report("out_chan_c", got.out_chan_c, want.out_chan_c);
        if (got.request_run != want.request_run)
            report("request_run", got.request_run, want.request_run);
        if (got.missing_count != want.missing_count)
            report("missing_count", got.missing_count, want.missing_count);
        if (got.expired_total != want.expired_total)
            report("expired_total", got.expired_total, want.expired_total);
        if (got.duplicate_total != want.duplicate_total)
            report("duplicate_total", got.duplicate_total, want.duplicate_total);
        if (got.received_total != want.received_total)
            report("received_total", got.received_total, want.received_total);
    endtask

    initial
    begin
        errs = 0;
        printed = 0;
        outstanding = 0;
        session_reg = 0;
        holdoff_reg = HOLDOFF_RESET;
        floor_seq = 0;
        next_seq = 0;
        started = 0;
        rejected = 0;
        held = 0;
        expired_cnt = 0;
        dup_cnt = 0;
        recv_cnt = 0;
        pend_start = 0;
        pend_run = 0;
        last_req = 0;
        for (int i = 0; i < WINDOW; i++)
            slot_held[i] = 0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_SESSION)
                    session_reg = cfg_data;
                else
                    holdoff_reg = cfg_data[15:0];
            end
            if (in_valid && in_ready)
                expected_results.push_back(window_result(in_data));
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report("unexpected result", out_data.result_kind, 0);
                else
                    compare_result(out_data, expected_results.pop_front());
            end
            outstanding <= expected_results.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the sample reorder window: a short directed pass
// over the special cases, then random phases of well-formed packet streams
// mixed with ticks, reads, noise and broken packets, under random idling on
// both channels and one long receiver hold-off
// ----------------------------------------------------------------------------
module testbench;
    import srw_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    in_t         in_data;
    logic        out_valid;
    logic        out_ready;
    out_t        out_data;
    int          fail_count;
    int          outstanding;

    // stimulus bookkeeping
    logic [31:0] session_cur;   // session the block is set to
    logic [31:0] stream_next;   // next sequence the stream will send
    logic [31:0] tick_now;      // time carried by ticks
    int          sent;          // command transactions accepted
    bit          quiet;         // no idling on either side while set
    bit          long_hold;     // receiver holds off for a long stretch

    sample_reorder_window_with_nack dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    srw_checker scoreboard (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .fail_count (fail_count),
        .outstanding(outstanding)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // one command transaction: random gap first, then hold valid until taken
    task automatic send_cmd(input in_t it);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (!in_ready);
        sent++;
    endtask

    // register write only with the block drained and any floor sweep over
    task automatic write_reg(input logic idx, input logic [31:0] val);
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (1100) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_SESSION)
            session_cur = val;
    endtask

    function automatic in_t blank_cmd(input logic [2:0] c);
        in_t it;
        it = '0;
        it.cmd = c;
        it.packet_session = session_cur;
        it.chan_a = 16'($urandom);
        it.chan_b = 16'($urandom);
        it.chan_c = 16'($urandom);
        return it;
    endfunction

    task automatic send_status(input logic [31:0] oldest, input logic [31:0] newest);
        in_t it;
        it = blank_cmd(CMD_STATUS);
        it.payload_size = STATUS_SIZE;
        it.chan_a = RATE_WORD;
        it.chan_b = CHAN_WORD;
        it.word_a = oldest;
        it.word_b = newest;
        send_cmd(it);
        if (newest > stream_next)
            stream_next = newest;
    endtask

    task automatic send_gap(input logic [31:0] upto);
        in_t it;
        it = blank_cmd(CMD_GAP);
        it.payload_size = GAP_SIZE;
        it.word_a = upto;
        send_cmd(it);
    endtask

    task automatic send_tick(input logic [31:0] now);
        in_t it;
        it = blank_cmd(CMD_TICK);
        it.word_a = now;
        send_cmd(it);
    endtask

    task automatic send_read(input logic [31:0] s);
        in_t it;
        it = blank_cmd(CMD_LOOKUP);
        it.seq_start = s;
        send_cmd(it);
    endtask

    // data packet: index 0 first, the rest in random order; when sloppy, some
    // samples are skipped to leave holes and some sent twice
    task automatic send_packet(input logic [31:0] start, input int cnt, input bit sloppy);
        in_t it;
        int order[$];
        int j;
        int t;
        it = blank_cmd(CMD_DATA);
        it.seq_start = start;
        it.sample_count = 8'(cnt);
        it.payload_size = 8'(cnt * 6);
        for (int i = 1; i < cnt; i++)
            order.push_back(i);
        for (int i = order.size() - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        order.push_front(0);
        foreach (order[i])
        begin
            if (sloppy && i > 0 && $urandom_range(0, 9) == 0)
                continue;
            it.sample_index = 5'(order[i]);
            it.chan_a = 16'($urandom);
            it.chan_b = 16'($urandom);
            it.chan_c = 16'($urandom);
            send_cmd(it);
            if (sloppy && $urandom_range(0, 14) == 0)
                send_cmd(it);
        end
        if (start + cnt > stream_next)
            stream_next = start + cnt;
    endtask

    function automatic logic [31:0] back_off(input logic [31:0] s, input int d);
        return (s > d) ? s - d : 32'd0;
    endfunction

    // receiver: random stalls per result, one long stretch on request
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (long_hold)
            begin
                stall = 400;
                long_hold = 0;
            end
            else
                stall = quiet ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial
    begin
        #40_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    initial
    begin
        in_t it;
        int pick;
        int cnt;
        int phase;
        logic [31:0] st;
        bit hold_done;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_SESSION;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        session_cur = 0;
        stream_next = 0;
        tick_now = 0;
        sent = 0;
        quiet = 0;
        long_hold = 0;
        hold_done = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed: behavior before the window starts
        send_read(32'd5);
        send_tick(32'd0);
        send_packet(32'd0, 2, 0);
        for (int c = 5; c < 8; c++)
            send_cmd(blank_cmd(3'(c)));

        // --- directed: status checks, then start at 10
        it = blank_cmd(CMD_STATUS);
        it.payload_size = STATUS_SIZE;
        it.chan_a = RATE_WORD;
        it.chan_b = CHAN_WORD;
        it.packet_session = 32'hFFFF_FFFF;
        send_cmd(it);                               // wrong session
        it.packet_session = session_cur;
        it.payload_size = 8'd19;
        send_cmd(it);                               // bad size
        it.payload_size = STATUS_SIZE;
        it.chan_a = 16'd251;
        send_cmd(it);                               // bad rate word
        it.chan_a = RATE_WORD;
        it.chan_b = 16'd4;
        send_cmd(it);                               // bad channel word
        it.chan_b = CHAN_WORD;
        it.word_a = 32'd9;
        it.word_b = 32'd8;
        send_cmd(it);                               // oldest above newest
        send_status(32'd10, 32'd10);

        // --- directed: broken data packets
        send_packet(32'd10, 0, 0);                  // zero count
        it = blank_cmd(CMD_DATA);
        it.seq_start = 32'd10;
        it.sample_count = 8'd26;
        it.payload_size = 8'd156;
        send_cmd(it);                               // count too large
        it.sample_count = 8'd3;
        it.payload_size = 8'd17;
        send_cmd(it);                               // size mismatch
        it.seq_start = 32'hFFFF_FFFD;
        it.sample_count = 8'd3;
        it.payload_size = 8'd18;
        send_cmd(it);                               // would run past the top

        // --- directed: a good packet, duplicate, index beyond count, holes
        send_packet(32'd10, 3, 0);
        send_packet(32'd11, 1, 0);                  // duplicate of held sample
        it = blank_cmd(CMD_DATA);
        it.seq_start = 32'd14;
        it.sample_count = 8'd25;
        it.payload_size = 8'd150;
        it.sample_index = 5'd0;
        send_cmd(it);
        it.sample_index = 5'd24;
        send_cmd(it);
        it.sample_count = 8'd2;
        it.sample_index = 5'd20;
        send_cmd(it);                               // beyond this packet's count
        stream_next = 32'd39;
        send_tick(32'd1000);
        send_tick(32'd1001);                        // held off
        send_read(32'd10);
        send_read(32'hFFFF_FFFF);
        send_gap(32'd5000);                         // beyond next
        it = blank_cmd(CMD_GAP);
        it.payload_size = 8'd9;
        it.word_a = 32'd12;
        send_cmd(it);                               // bad gap size
        send_gap(32'd12);
        send_packet(32'd11, 1, 0);                  // now below the floor
        tick_now = 32'd2000;

        // --- random phases, each under its own register setting
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: write_reg(CFG_HOLDOFF, 32'd0);
                1: write_reg(CFG_SESSION, 32'hFFFF_FFFF);
                2: write_reg(CFG_HOLDOFF, 32'hFFFF);
                3: write_reg(CFG_SESSION, $urandom);
                4: write_reg(CFG_HOLDOFF, $urandom_range(1, 300));
                default: write_reg(CFG_HOLDOFF, 32'd100);
            endcase
            while (sent < 100 + phase * 96)
            begin
                if (sent % 60 < 12)
                    quiet = 1;
                else
                    quiet = 0;
                if (phase == 2 && !hold_done && sent > 230)
                begin
                    long_hold = 1;
                    hold_done = 1;
                end
                pick = $urandom_range(0, 99);
                if (pick < 48)
                begin
                    cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 25)
                                                      : $urandom_range(1, 6);
                    case ($urandom_range(0, 5))
                        0: st = back_off(stream_next, $urandom_range(1, 60));
                        1: st = stream_next + $urandom_range(1, 40);
                        default: st = stream_next;
                    endcase
                    send_packet(st, cnt, 1);
                end
                else if (pick < 64)
                begin
                    tick_now = tick_now + $urandom_range(0, 150);
                    send_tick(tick_now);
                end
                else if (pick < 74)
                    send_read(back_off(stream_next, $urandom_range(0, 80)));
                else if (pick < 80)
                begin
                    st = stream_next + $urandom_range(0, 5);
                    send_status(back_off(st, $urandom_range(20, 1200)), st);
                end
                else if (pick < 84)
                    send_gap(back_off(stream_next, $urandom_range(0, 300)));
                else
                begin
                    // noise: random fields, session right half the time
                    it.cmd = 3'($urandom_range(0, 7));
                    it.packet_session = $urandom_range(0, 1) ? session_cur : $urandom;
                    it.payload_size = 8'($urandom);
                    it.seq_start = $urandom;
                    it.sample_count = 8'($urandom);
                    it.sample_index = 5'($urandom_range(0, 24));
                    it.chan_a = 16'($urandom);
                    it.chan_b = 16'($urandom);
                    it.chan_c = 16'($urandom);
                    it.word_a = $urandom;
                    it.word_b = $urandom;
                    send_cmd(it);
                end
            end
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (1200) @(posedge clk);
        if (fail_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule
